/* rtl/first_match_address_range_table_macros.svh */
// ----------------------------------------------------------------------------
// first_match_address_range_table_macros
// assertion macros used by the range table top level
// ----------------------------------------------------------------------------
`ifndef FIRST_MATCH_ADDRESS_RANGE_TABLE_MACROS_SVH
`define FIRST_MATCH_ADDRESS_RANGE_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS
// plain property, checked on every clock outside reset
`define FMART_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("range table check failed");
// antecedent this cycle implies consequent on the next cycle
`define FMART_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("range table sequence check failed");
`else
`define FMART_ASSERT(lbl, prop)
`define FMART_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/fmart_pkg.sv */
// ----------------------------------------------------------------------------
// fmart_pkg
// types, codes and defaults of the first-match address range table
// ----------------------------------------------------------------------------
package fmart_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    // command codes
    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_ADD     = 2'd1;
    localparam logic [1:0] CMD_RESOLVE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] range_base;
        logic [63:0] range_size;
        logic [31:0] section_flags;
        logic [63:0] lookup_address;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] match_flags;
        logic        overflowed;
        logic [8:0]  entry_count;
    } t_rsp;

    // one stored range
    typedef struct packed {
        logic [63:0] base;
        logic [63:0] size;
        logic [31:0] flags;
    } t_entry;

endpackage

/* rtl/fmart_chan_if.sv */
// ----------------------------------------------------------------------------
// fmart_chan_if
// valid/ready channel carrying one payload item per transfer
// ----------------------------------------------------------------------------
interface fmart_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/fmart_mem.sv */
// ----------------------------------------------------------------------------
// fmart_mem
// range storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module fmart_mem #(
    parameter int TABLE_DEPTH = fmart_pkg::TABLE_DEPTH_DEF,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  fmart_pkg::t_entry i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output fmart_pkg::t_entry o_rd_data
);
    import fmart_pkg::*;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/fmart_ctrl.sv */
// ----------------------------------------------------------------------------
// fmart_ctrl
// command sequencer: count and overflow state, append writes, in-order scan
// ----------------------------------------------------------------------------
module fmart_ctrl #(
    parameter int TABLE_DEPTH = fmart_pkg::TABLE_DEPTH_DEF,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  fmart_pkg::t_cmd   i_cmd,
    output logic              o_cmd_ready,
    output logic              o_res_valid,
    output fmart_pkg::t_rsp   o_res,
    input  logic              i_res_ready,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output fmart_pkg::t_entry o_wr_data,
    output logic              o_rd_en,
    output logic [AW-1:0]     o_rd_addr,
    input  fmart_pkg::t_entry i_rd_data
);
    import fmart_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic          r_ovf;
    logic [63:0]   r_addr;
    t_rsp          r_res;

    logic          accept;
    logic          full;
    logic          hit;
    logic          last;
    logic [CW-1:0] idx_nxt;
    logic [CW-1:0] count_inc;

    // no transfer while reset is held
    assign o_cmd_ready = (r_state == S_IDLE) && i_rst_n;
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    assign accept    = i_cmd_valid && o_cmd_ready;
    assign full      = (r_count >= DEPTH_C);
    assign idx_nxt   = r_idx + 1'b1;
    assign count_inc = r_count + 1'b1;
    assign last      = (idx_nxt == r_count);

    // base <= addr first, so the offset subtract cannot wrap
    assign hit = (i_rd_data.base <= r_addr) && ((r_addr - i_rd_data.base) < i_rd_data.size);

    // appends land at the current count
    assign o_wr_en         = accept && (i_cmd.command == CMD_ADD)
                             && (i_cmd.range_size != 64'd0) && !full;
    assign o_wr_addr       = AW'(r_count);
    assign o_wr_data.base  = i_cmd.range_base;
    assign o_wr_data.size  = i_cmd.range_size;
    assign o_wr_data.flags = i_cmd.section_flags;

    // entry 0 is fetched on the resolve transfer, then one entry per cycle
    assign o_rd_en   = (accept && (i_cmd.command == CMD_RESOLVE))
                       || ((r_state == S_SCAN) && !hit && !last);
    assign o_rd_addr = (r_state == S_SCAN) ? AW'(idx_nxt) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
            r_addr  <= '0;
            r_res   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res.status      <= ST_OK;
                        r_res.match_flags <= '0;
                        r_res.overflowed  <= r_ovf;
                        r_res.entry_count <= 9'(r_count);
                        r_state           <= S_DONE;
                        unique case (i_cmd.command)
                            CMD_CLEAR: begin
                                r_count           <= '0;
                                r_ovf             <= 1'b0;
                                r_res.overflowed  <= 1'b0;
                                r_res.entry_count <= '0;
                            end
                            CMD_ADD: begin
                                if (i_cmd.range_size == 64'd0) begin
                                    r_res.status <= ST_BAD_SIZE;
                                end else if (full) begin
                                    r_ovf            <= 1'b1;
                                    r_res.status     <= ST_FULL;
                                    r_res.overflowed <= 1'b1;
                                end else begin
                                    r_count           <= count_inc;
                                    r_res.entry_count <= 9'(count_inc);
                                end
                            end
                            CMD_RESOLVE: begin
                                r_addr <= i_cmd.lookup_address;
                                r_idx  <= '0;
                                if (r_count != '0) begin
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                                // unused code: no state change, plain ok result
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_res.match_flags <= i_rd_data.flags;
                        r_state           <= S_DONE;
                    end else if (last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= idx_nxt;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/first_match_address_range_table.sv */
// ----------------------------------------------------------------------------
// first_match_address_range_table
// table of address ranges with append, clear and first-match resolve
// ----------------------------------------------------------------------------
// One command is taken at a time and each gives one response. Clear, add and
// the unused code go straight from the transfer to the response. Resolve reads
// the ranges from one synchronous memory port, one entry per cycle from entry
// 0 upward, and stops at the first match, at the last stored entry on a miss,
// or at once on an empty table. The response sits in an output register, so the
// next command is taken while a finished response waits to be picked up.
// Entries are reached only below the stored count, so the memory needs no
// clearing after reset.
`include "first_match_address_range_table_macros.svh"

module first_match_address_range_table #(
    parameter int TABLE_DEPTH = fmart_pkg::TABLE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fmart_chan_if.sink   i_cmd,
    fmart_chan_if.source o_rsp
);
    import fmart_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic          res_valid;
    logic          res_ready;
    t_rsp          res;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_entry        rd_data;

    logic          r_out_valid;
    t_rsp          r_out;

    fmart_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .i_cmd       (i_cmd.payload),
        .o_cmd_ready (i_cmd.ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    fmart_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // output stage: refills in the same cycle the held response transfers
    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    `FMART_ASSERT(a_full_marks_ovf, (o_rsp.valid && (o_rsp.payload.status == ST_FULL)) |-> o_rsp.payload.overflowed)
    `FMART_ASSERT(a_err_no_match, (o_rsp.valid && (o_rsp.payload.status != ST_OK)) |-> (o_rsp.payload.match_flags == 32'd0))
    `FMART_ASSERT_NEXT(a_busy_after_cmd, i_cmd.valid && i_cmd.ready, !i_cmd.ready)
    `FMART_ASSERT_NEXT(a_no_rd_wr_mix, wr_en, !rd_en && !wr_en)

endmodule

/* tb/range_table_checker.sv */
// ----------------------------------------------------------------------------
// range_table_checker
// Watches the command and response channels of the range table. It keeps its
// own copy of the stored ranges, works out the response to every command taken,
// and compares each response taken by the receiver, field by field, with the
// oldest one still due.
// ----------------------------------------------------------------------------
module range_table_checker #(
    parameter int DEPTH = fmart_pkg::TABLE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  logic            i_cmd_ready,
    input  fmart_pkg::t_cmd i_cmd,
    input  logic            i_rsp_valid,
    input  logic            i_rsp_ready,
    input  fmart_pkg::t_rsp i_rsp,
    output int              o_err_count,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import fmart_pkg::*;

    localparam int MAX_PRINTS = 60;

    logic [63:0] range_base [DEPTH];
    logic [63:0] range_size [DEPTH];
    logic [31:0] range_flags [DEPTH];
    int unsigned n_ranges;
    logic        full_seen;

    t_rsp rsp_due [$];
    int   err_total;
    int   rsp_index;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_total++;
        if (err_total <= MAX_PRINTS) begin
            $display("%0t: response %0d %s: got %0h, expected %0h",
                     $realtime, rsp_index, what, got, want);
        end
    endtask

    // updates the table copy and returns the response the command should give
    function automatic t_rsp apply_table_cmd(input t_cmd c);
        t_rsp        r;
        int unsigned i;
        logic        hit;
        r = '0;
        r.status = ST_OK;
        case (c.command)
            CMD_CLEAR: begin
                n_ranges  = 0;
                full_seen = 1'b0;
            end
            CMD_ADD: begin
                if (c.range_size == '0) begin
                    r.status = ST_BAD_SIZE;
                end else if (n_ranges >= DEPTH) begin
                    full_seen = 1'b1;
                    r.status  = ST_FULL;
                end else begin
                    range_base[n_ranges]  = c.range_base;
                    range_size[n_ranges]  = c.range_size;
                    range_flags[n_ranges] = c.section_flags;
                    n_ranges++;
                end
            end
            CMD_RESOLVE: begin
                hit = 1'b0;
                for (i = 0; i < n_ranges && !hit; i++) begin
                    // offset taken only once base <= address, so no wrap
                    if (c.lookup_address >= range_base[i] &&
                        (c.lookup_address - range_base[i]) < range_size[i]) begin
                        r.match_flags = range_flags[i];
                        hit = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.overflowed  = full_seen;
        r.entry_count = 9'(n_ranges);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            n_ranges  = 0;
            full_seen = 1'b0;
            rsp_due.delete();
            err_total = 0;
            rsp_index = 0;
        end else begin
            // responses first: one leaving now belongs to an older command
            if (i_rsp_valid && i_rsp_ready) begin
                if (rsp_due.size() == 0) begin
                    report_mismatch("with nothing due, entry_count", 64'(i_rsp.entry_count),
                                    64'h0);
                end else begin
                    want = rsp_due.pop_front();
                    if (i_rsp.status !== want.status)
                        report_mismatch("status", 64'(i_rsp.status), 64'(want.status));
                    if (i_rsp.match_flags !== want.match_flags)
                        report_mismatch("match_flags", 64'(i_rsp.match_flags),
                                        64'(want.match_flags));
                    if (i_rsp.overflowed !== want.overflowed)
                        report_mismatch("overflowed", 64'(i_rsp.overflowed),
                                        64'(want.overflowed));
                    if (i_rsp.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 64'(i_rsp.entry_count),
                                        64'(want.entry_count));
                end
                rsp_index++;
            end
            if (i_cmd_valid && i_cmd_ready) begin
                rsp_due.push_back(apply_table_cmd(i_cmd));
            end
        end
        o_pending   <= rsp_due.size();
        o_err_count <= err_total;
    end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives the range table with clear, add, resolve and unused commands: a short
// directed list of edge cases, then table sessions with random ranges and
// lookups aimed at stored ranges, including fills past the table depth. Both
// sides idle at random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fmart_pkg::*;

    localparam int         DEPTH        = TABLE_DEPTH_DEF;
    localparam int         N_ITEMS      = 1450;
    localparam int         LONG_HOLD    = 400;
    localparam int         TAIL_CYCLES  = 300;
    localparam int         LIMIT_CYCLES = 4_000_000;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    logic hold_req;
    int   err_count;
    int   pending;
    int   cycles = 0;

    int          items_sent = 0;
    bit          gapless = 1'b0;
    logic [63:0] region;
    logic [63:0] added_base [$];
    logic [63:0] added_size [$];

    fmart_chan_if #(.T(t_cmd)) cmd_ch ();
    fmart_chan_if #(.T(t_rsp)) rsp_ch ();

    first_match_address_range_table #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_cmd  (cmd_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    range_table_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cmd_valid(cmd_ch.valid),
        .i_cmd_ready(cmd_ch.ready),
        .i_cmd      (cmd_ch.payload),
        .i_rsp_valid(rsp_ch.valid),
        .i_rsp_ready(rsp_ch.ready),
        .i_rsp      (rsp_ch.payload),
        .o_err_count(err_count),
        .o_pending  (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("[first_match_address_range_table] ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_cmd cmd_item(input logic [1:0] op, input logic [63:0] base,
                                      input logic [63:0] size, input logic [31:0] flags,
                                      input logic [63:0] addr);
        t_cmd c;
        c.command        = op;
        c.range_base     = base;
        c.range_size     = size;
        c.section_flags  = flags;
        c.lookup_address = addr;
        return c;
    endfunction

    function automatic t_cmd rand_item(input logic [1:0] op);
        return cmd_item(op, rand64(), rand64(), $urandom, rand64());
    endfunction

    // ranges mostly clustered around the session region so lookups overlap
    function automatic t_cmd make_add();
        t_cmd c;
        int   mode;
        c    = rand_item(CMD_ADD);
        mode = $urandom_range(0, 9);
        if (mode == 1) begin
            c.range_base = ~64'h0 - 64'($urandom_range(0, 4095));
        end else if (mode == 2) begin
            c.range_base = region + 64'($urandom_range(0, 8191));
            c.range_size = 64'h1;
        end else if (mode >= 3) begin
            c.range_base = region + 64'($urandom_range(0, 8191));
            c.range_size = 64'($urandom_range(1, 2048));
        end
        if (c.range_size == '0)
            c.range_size = 64'h1;
        return c;
    endfunction

    function automatic t_cmd make_resolve();
        t_cmd        c;
        int          k;
        logic [63:0] base;
        logic [63:0] size;
        logic [63:0] span;
        c = rand_item(CMD_RESOLVE);
        if (added_base.size() > 0 && $urandom_range(0, 99) < 75) begin
            k    = $urandom_range(0, added_base.size() - 1);
            base = added_base[k];
            size = added_size[k];
            case ($urandom_range(0, 5))
                0: c.lookup_address = base;
                1: begin
                    // last byte, clipped at the top of the address space
                    span = size - 1;
                    if (span > ~base)
                        span = ~base;
                    c.lookup_address = base + span;
                end
                2: c.lookup_address = base + size;
                3: c.lookup_address = base - 1;
                default: c.lookup_address = base + rand64() % size;
            endcase
        end else if ($urandom_range(0, 1) == 0) begin
            c.lookup_address = region + 64'($urandom_range(0, 10000));
        end
        return c;
    endfunction

    task automatic issue(input t_cmd c);
        int gap;
        int r;
        gap = 0;
        if (!gapless) begin
            r = $urandom_range(0, 99);
            if (r >= 98)
                gap = $urandom_range(20, 60);
            else if (r >= 90)
                gap = $urandom_range(4, 10);
            else if (r >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= c;
        do @(posedge clk); while (!cmd_ch.ready);
        // shadow list of reachable ranges, used to aim lookups and to spot a full table
        if (c.command == CMD_CLEAR) begin
            added_base.delete();
            added_size.delete();
        end else if (c.command == CMD_ADD && c.range_size != '0 &&
                     added_base.size() < DEPTH) begin
            added_base.push_back(c.range_base);
            added_size.push_back(c.range_size);
        end
        if (c.command != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic wait_all_responses();
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic run_session(input int fill, input bit force_clear);
        t_cmd c;
        int   adds;
        int   r;
        r = $urandom_range(0, 3);
        if (r == 0)
            region = '0;
        else if (r == 1)
            region = ~64'h0 - 64'h10000;
        else
            region = rand64();
        if (force_clear || $urandom_range(0, 99) < 85)
            issue(rand_item(CMD_CLEAR));
        adds = 0;
        while (adds < fill && items_sent < N_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                issue(make_add());
                adds++;
            end else if (r < 54) begin
                c = rand_item(CMD_ADD);
                c.range_size = '0;
                issue(c);
            end else if (r < 94) begin
                issue(make_resolve());
            end else if (r < 97) begin
                issue(rand_item(CMD_UNUSED));
            end else if (fill < 64) begin
                issue(rand_item(CMD_CLEAR));
            end else begin
                issue(make_resolve());
            end
        end
        if (added_base.size() == DEPTH) begin
            // refused adds, then a zero size on the full table
            repeat ($urandom_range(2, 5)) issue(make_add());
            c = rand_item(CMD_ADD);
            c.range_size = '0;
            issue(c);
        end
        repeat ($urandom_range(2, 8)) issue(make_resolve());
    endtask

    // receiver: short random stalls, free-running stretches, one long hold-off
    initial begin : rsp_ready_drive
        int low_left;
        int run_left;
        int r;
        bit hold_served;
        low_left    = 0;
        run_left    = 0;
        hold_served = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end else if (run_left > 0) begin
                run_left--;
                rsp_ch.ready <= 1'b1;
            end else if (low_left > 0) begin
                low_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    run_left = $urandom_range(40, 200);
                    rsp_ch.ready <= 1'b1;
                end else if (r < 7) begin
                    low_left = $urandom_range(15, 60);
                    rsp_ch.ready <= 1'b0;
                end else if (r < 27) begin
                    low_left = $urandom_range(0, 2);
                    rsp_ch.ready <= 1'b0;
                end else begin
                    rsp_ch.ready <= 1'b1;
                end
            end
        end
    end

    initial begin : stimulus
        int session;
        int r;
        int fill;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.payload <= '0;
        hold_req       <= 1'b0;
        rst_n          <= 1'b0;
        region          = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        issue(cmd_item(CMD_RESOLVE, '0, '0, '0, 64'h0));             // empty table
        issue(cmd_item(CMD_ADD, 64'h0, 64'h0, 32'hDEAD_BEEF, 64'h0));  // zero size
        issue(cmd_item(CMD_ADD, 64'h0, 64'h1, 32'h0000_0001, '1));
        issue(cmd_item(CMD_RESOLVE, '1, '1, '1, 64'h0));
        issue(cmd_item(CMD_RESOLVE, '0, '0, '0, 64'h1));
        issue(cmd_item(CMD_ADD, '1, '1, '1, '0));                      // last byte of space
        issue(cmd_item(CMD_RESOLVE, '0, '0, '0, '1));
        issue(cmd_item(CMD_RESOLVE, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE));
        // overlapping ranges: the lower entry wins
        issue(cmd_item(CMD_ADD, 64'd100, 64'd50, 32'h0000_00A0, '0));
        issue(cmd_item(CMD_ADD, 64'd120, 64'd100, 32'h0000_00B0, '0));
        issue(cmd_item(CMD_RESOLVE, '0, '0, '0, 64'd130));
        issue(cmd_item(CMD_RESOLVE, '0, '0, '0, 64'd149));
        issue(cmd_item(CMD_RESOLVE, '0, '0, '0, 64'd150));
        issue(cmd_item(CMD_RESOLVE, '0, '0, '0, 64'd219));
        issue(cmd_item(CMD_RESOLVE, '0, '0, '0, 64'd220));
        issue(cmd_item(CMD_RESOLVE, '0, '0, '0, 64'd99));
        // upper half, base plus size lands exactly on the wrap
        issue(cmd_item(CMD_ADD, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                       32'h1234_5678, '0));
        issue(cmd_item(CMD_RESOLVE, '0, '0, '0, '1));
        issue(cmd_item(CMD_RESOLVE, '0, '0, '0, 64'h8000_0000_0000_0000));
        issue(cmd_item(CMD_RESOLVE, '0, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF));
        issue(rand_item(CMD_UNUSED));
        issue(cmd_item(CMD_ADD, '1, 64'h0, '1, '1));
        issue(cmd_item(CMD_CLEAR, '0, '0, '0, '0));
        issue(cmd_item(CMD_RESOLVE, '0, '0, '0, 64'd130));            // stale entry
        issue(cmd_item(CMD_ADD, 64'd130, '1, 32'h0000_5A5A, '0));
        issue(cmd_item(CMD_RESOLVE, '0, '0, '0, '1));
        wait_all_responses();

        session = 0;
        while (items_sent < N_ITEMS) begin
            r = $urandom_range(0, 99);
            if (session == 0 || r < 6)
                fill = DEPTH;
            else if (r < 26)
                fill = $urandom_range(17, 80);
            else
                fill = $urandom_range(1, 16);
            gapless = (session == 2) || ($urandom_range(0, 99) < 25);
            if (session == 2)
                hold_req <= 1'b1;
            run_session(fill, session == 0);
            if ($urandom_range(0, 99) < 15)
                wait_all_responses();
            session++;
        end

        wait_all_responses();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0 && pending == 0) begin
            $display("[first_match_address_range_table] OK");
        end else begin
            $display("[first_match_address_range_table] ERROR");
        end
        $finish;
    end

endmodule

/* first_match_address_range_table.f */
+incdir+rtl
rtl/fmart_pkg.sv
rtl/fmart_chan_if.sv
rtl/fmart_mem.sv
rtl/fmart_ctrl.sv
rtl/first_match_address_range_table.sv
tb/range_table_checker.sv
tb/tb.sv
